// ===== rtl/core/hex_text_to_bytes_parser_macros.svh =====
// Assertion helpers for the hex text parser.
`ifndef HEX_TEXT_TO_BYTES_PARSER_MACROS_SVH
`define HEX_TEXT_TO_BYTES_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HTBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HTBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/htbp_pkg.sv =====
package htbp_pkg;

    localparam logic [15:0] MAX_BYTES_RESET = 16'hFFFF;

    localparam logic [2:0] KIND_DATA     = 3'd0;
    localparam logic [2:0] KIND_OK       = 3'd1;
    localparam logic [2:0] KIND_JUNK     = 3'd2;
    localparam logic [2:0] KIND_OVERFLOW = 3'd3;
    localparam logic [2:0] KIND_DANGLING = 3'd4;

    localparam logic [1:0] REASON_JUNK     = 2'd0;
    localparam logic [1:0] REASON_OVERFLOW = 2'd1;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] DIGIT_TEN = 8'd10;

    function automatic logic is_separator(logic [7:0] ch);
        return (ch == CH_SPACE) || (ch == CH_COLON) || (ch == CH_DASH) ||
               (ch == CH_COMMA) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_NL);
    endfunction

    // {hit, nibble}
    function automatic logic [4:0] hex_decode(logic [7:0] ch);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'd0;
        r = 5'd0;
        if (ch >= CH_0 && ch <= CH_9)
        begin
            d = ch - CH_0;
            r = {1'b1, d[3:0]};
        end
        else if (ch >= CH_LOW_A && ch <= CH_LOW_F)
        begin
            d = ch - CH_LOW_A + DIGIT_TEN;
            r = {1'b1, d[3:0]};
        end
        else if (ch >= CH_UP_A && ch <= CH_UP_F)
        begin
            d = ch - CH_UP_A + DIGIT_TEN;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/hex_text_to_bytes_parser.sv =====
// Hex text to bytes parser.
// Input channel (in_valid / in_stall): one item per cycle while in_stall is low, opcode 0 carries
// one ASCII character in char_code, opcode 1 marks the end of the string.
// Output channel (out_valid / out_stall): kind, byte_value, byte_count.
// A character item gives a result only when it completes a byte; an end
// item always gives one result (ok with the length, a dangling digit, or
// the failure reason) and clears the string state. Separators are skipped,
// a "0x"/"0X" prefix at a byte boundary is dropped.
// Path: an accepted item passes the input register, then the result
// register, which drives the port.
// Throughput: one item per cycle while no stall holds, set by the combinational
// update of the parser state between the input register and the result register.
// Stall: while a result waits with out_stall high, in_stall is raised and
// both stages hold; items without results never occupy the output.
// Reset: max_bytes returns to 65535, string state clears, both stages empty.
// cfg_write_en / cfg_write_data write max_bytes; write only while idle.
`include "hex_text_to_bytes_parser_macros.svh"

module hex_text_to_bytes_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  byte_value,
    output logic [15:0] byte_count,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data
);

    logic        advance;

    logic        s1_valid_reg;
    logic        s1_opcode_reg;
    logic [7:0]  s1_char_reg;

    logic [15:0] max_bytes_reg;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic        nibble_pending_reg, nibble_pending_next;
    logic        zero_pending_reg, zero_pending_next;
    logic        failed_reg, failed_next;
    logic [1:0]  failure_reason_reg, failure_reason_next;
    logic [15:0] count_reg, count_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  byte_value_reg, byte_value_next;
    logic [15:0] byte_count_reg, byte_count_next;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    always_comb
    begin
        logic [4:0] dec;
        logic       hold_nib;
        logic [3:0] hn;
        dec      = htbp_pkg::hex_decode(s1_char_reg);
        hold_nib = nibble_pending_reg;
        hn       = high_nibble_reg;

        high_nibble_next    = high_nibble_reg;
        nibble_pending_next = nibble_pending_reg;
        zero_pending_next   = zero_pending_reg;
        failed_next         = failed_reg;
        failure_reason_next = failure_reason_reg;
        count_next          = count_reg;
        out_valid_next      = 1'b0;
        kind_next           = htbp_pkg::KIND_DATA;
        byte_value_next     = 8'd0;
        byte_count_next     = count_reg;

        if (s1_valid_reg)
        begin
            if (s1_opcode_reg == htbp_pkg::OP_END)
            begin
                out_valid_next = 1'b1;
                if (failed_reg)
                    kind_next = (failure_reason_reg == htbp_pkg::REASON_OVERFLOW) ?
                                htbp_pkg::KIND_OVERFLOW : htbp_pkg::KIND_JUNK;
                else if (nibble_pending_reg || zero_pending_reg)
                    kind_next = htbp_pkg::KIND_DANGLING;
                else
                    kind_next = htbp_pkg::KIND_OK;
                high_nibble_next    = 4'd0;
                nibble_pending_next = 1'b0;
                zero_pending_next   = 1'b0;
                failed_next         = 1'b0;
                failure_reason_next = htbp_pkg::REASON_JUNK;
                count_next          = 16'd0;
            end
            else if (!failed_reg)
            begin
                // held zero: prefix drop, or it becomes the high nibble
                if (zero_pending_reg && (s1_char_reg == htbp_pkg::CH_LOW_X ||
                                         s1_char_reg == htbp_pkg::CH_UP_X))
                begin
                    zero_pending_next = 1'b0;
                end
                else
                begin
                    if (zero_pending_reg)
                    begin
                        zero_pending_next   = 1'b0;
                        hold_nib            = 1'b1;
                        hn                  = 4'd0;
                        high_nibble_next    = 4'd0;
                        nibble_pending_next = 1'b1;
                    end
                    if (htbp_pkg::is_separator(s1_char_reg))
                    begin
                        // skipped
                    end
                    else if (!hold_nib && s1_char_reg == htbp_pkg::CH_0)
                    begin
                        zero_pending_next = 1'b1;
                    end
                    else if (!dec[4])
                    begin
                        failed_next         = 1'b1;
                        failure_reason_next = htbp_pkg::REASON_JUNK;
                    end
                    else if (!hold_nib)
                    begin
                        high_nibble_next    = dec[3:0];
                        nibble_pending_next = 1'b1;
                    end
                    else if (count_reg >= max_bytes_reg)
                    begin
                        failed_next         = 1'b1;
                        failure_reason_next = htbp_pkg::REASON_OVERFLOW;
                    end
                    else
                    begin
                        count_next          = count_reg + 16'd1;
                        nibble_pending_next = 1'b0;
                        high_nibble_next    = 4'd0;
                        out_valid_next      = 1'b1;
                        kind_next           = htbp_pkg::KIND_DATA;
                        byte_value_next     = {hn, dec[3:0]};
                        byte_count_next     = count_reg + 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            max_bytes_reg      <= htbp_pkg::MAX_BYTES_RESET;
            high_nibble_reg    <= 4'd0;
            nibble_pending_reg <= 1'b0;
            zero_pending_reg   <= 1'b0;
            failed_reg         <= 1'b0;
            failure_reason_reg <= htbp_pkg::REASON_JUNK;
            count_reg          <= 16'd0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                max_bytes_reg <= cfg_write_data;
            if (advance)
            begin
                s1_valid_reg       <= in_valid;
                high_nibble_reg    <= high_nibble_next;
                nibble_pending_reg <= nibble_pending_next;
                zero_pending_reg   <= zero_pending_next;
                failed_reg         <= failed_next;
                failure_reason_reg <= failure_reason_next;
                count_reg          <= count_next;
                out_valid_reg      <= out_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_opcode_reg  <= opcode;
            s1_char_reg    <= char_code;
            kind_reg       <= kind_next;
            byte_value_reg <= byte_value_next;
            byte_count_reg <= byte_count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign byte_value = byte_value_reg;
    assign byte_count = byte_count_reg;

    `HTBP_ASSERT_NOW(a_data_count_nonzero,
        out_valid && kind == htbp_pkg::KIND_DATA, byte_count != 16'd0,
        "data item with zero byte count")

    `HTBP_ASSERT_NOW(a_status_value_zero,
        out_valid && kind != htbp_pkg::KIND_DATA, byte_value == 8'd0,
        "status item with nonzero byte value")

    `HTBP_ASSERT_NOW(a_pending_exclusive,
        1'b1, !(zero_pending_reg && nibble_pending_reg),
        "held zero and held nibble at once")

    `HTBP_ASSERT_NEXT(a_end_clears,
        advance && s1_valid_reg && s1_opcode_reg == htbp_pkg::OP_END,
        count_reg == 16'd0 && !failed_reg && !nibble_pending_reg && !zero_pending_reg
            && out_valid_reg,
        "end item did not clear string state")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [15:0] total;
} parse_result_t;

class hex_byte_scoreboard;
    logic [15:0]   capacity;
    logic [3:0]    high_digit;
    logic          digit_held;
    logic          zero_held;
    logic          string_failed;
    logic [1:0]    fail_reason;
    logic [15:0]   byte_total;
    parse_result_t expected_q[$];
    int            errors;
    int            results_seen;

    function new();
        capacity = htbp_pkg::MAX_BYTES_RESET;
        errors = 0;
        results_seen = 0;
        clear_string();
    endfunction

    function void clear_string();
        high_digit = 4'd0;
        digit_held = 1'b0;
        zero_held = 1'b0;
        string_failed = 1'b0;
        fail_reason = htbp_pkg::REASON_JUNK;
        byte_total = 16'd0;
    endfunction

    function void set_capacity(logic [15:0] v);
        capacity = v;
    endfunction

    function int pending_count();
        return expected_q.size();
    endfunction

    function logic skip_char(logic [7:0] ch);
        return ch == htbp_pkg::CH_SPACE || ch == htbp_pkg::CH_COLON ||
               ch == htbp_pkg::CH_DASH || ch == htbp_pkg::CH_COMMA ||
               ch == htbp_pkg::CH_TAB || ch == htbp_pkg::CH_CR ||
               ch == htbp_pkg::CH_NL;
    endfunction

    // {valid, digit}
    function logic [4:0] digit_of(logic [7:0] ch);
        logic [7:0] d;
        d = 8'd0;
        if (ch >= htbp_pkg::CH_0 && ch <= htbp_pkg::CH_9)
        begin
            d = ch - htbp_pkg::CH_0;
            return {1'b1, d[3:0]};
        end
        if (ch >= htbp_pkg::CH_LOW_A && ch <= htbp_pkg::CH_LOW_F)
        begin
            d = ch - htbp_pkg::CH_LOW_A + htbp_pkg::DIGIT_TEN;
            return {1'b1, d[3:0]};
        end
        if (ch >= htbp_pkg::CH_UP_A && ch <= htbp_pkg::CH_UP_F)
        begin
            d = ch - htbp_pkg::CH_UP_A + htbp_pkg::DIGIT_TEN;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    function void note_item(logic op, logic [7:0] ch);
        parse_result_t r;
        logic [4:0]    dv;
        if (op == htbp_pkg::OP_END)
        begin
            r.value = 8'd0;
            r.total = byte_total;
            if (string_failed)
                r.kind = (fail_reason == htbp_pkg::REASON_OVERFLOW) ?
                         htbp_pkg::KIND_OVERFLOW : htbp_pkg::KIND_JUNK;
            else if (digit_held || zero_held)
                r.kind = htbp_pkg::KIND_DANGLING;
            else
                r.kind = htbp_pkg::KIND_OK;
            clear_string();
            expected_q.push_back(r);
            return;
        end
        if (string_failed)
            return;
        if (zero_held)
        begin
            zero_held = 1'b0;
            if (ch == htbp_pkg::CH_LOW_X || ch == htbp_pkg::CH_UP_X)
                return;
            high_digit = 4'd0;
            digit_held = 1'b1;
        end
        if (skip_char(ch))
            return;
        if (!digit_held && ch == htbp_pkg::CH_0)
        begin
            zero_held = 1'b1;
            return;
        end
        dv = digit_of(ch);
        if (!dv[4])
        begin
            string_failed = 1'b1;
            fail_reason = htbp_pkg::REASON_JUNK;
            return;
        end
        if (!digit_held)
        begin
            high_digit = dv[3:0];
            digit_held = 1'b1;
            return;
        end
        if (byte_total >= capacity)
        begin
            string_failed = 1'b1;
            fail_reason = htbp_pkg::REASON_OVERFLOW;
            return;
        end
        byte_total = byte_total + 16'd1;
        digit_held = 1'b0;
        r.kind = htbp_pkg::KIND_DATA;
        r.value = {high_digit, dv[3:0]};
        r.total = byte_total;
        high_digit = 4'd0;
        expected_q.push_back(r);
    endfunction

    function void field_mismatch(string field, int want, int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                 $time, field, want, want, got, got);
    endfunction

    function void check_result(logic [2:0] k, logic [7:0] v, logic [15:0] n);
        parse_result_t e;
        results_seen++;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none, %s %0d value 0x%0h count %0d",
                     $time, "actual kind", k, v, n);
            return;
        end
        e = expected_q.pop_front();
        if (k !== e.kind)
            field_mismatch("kind", e.kind, k);
        if (v !== e.value)
            field_mismatch("byte_value", e.value, v);
        if (n !== e.total)
            field_mismatch("byte_count", e.total, n);
    endfunction
endclass

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD = 80;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [7:0]  char_code;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [15:0] byte_count;
    logic        cfg_write_en;
    logic [15:0] cfg_write_data;

    hex_byte_scoreboard sb;

    int src_idle_pct;
    int sink_idle_pct;
    int items_sent;
    int strings_sent;
    int hold_left;
    logic long_hold_req;
    int quiet;

    hex_text_to_bytes_parser uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .char_code      (char_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .byte_value     (byte_value),
        .byte_count     (byte_count),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // output side: random stall, plus one long hold on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(kind, byte_value, byte_count);
    end

    initial
    begin
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("%0t: timeout, no item moved for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, sb.pending_count());
        $display("*** FAILED ***");
        $finish;
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(logic op, logic [7:0] ch);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        char_code <= ch;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(op, ch);
        items_sent++;
        if (op == htbp_pkg::OP_END)
            strings_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(htbp_pkg::OP_CHAR, s[i]);
        send_item(htbp_pkg::OP_END, 8'd0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_count() > 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_capacity(logic [15:0] v);
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        sb.set_capacity(v);
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char();
        case ($urandom_range(3))
            0: return htbp_pkg::CH_0;
            1: return htbp_pkg::CH_0 + 8'($urandom_range(9));
            2: return htbp_pkg::CH_LOW_A + 8'($urandom_range(5));
            default: return htbp_pkg::CH_UP_A + 8'($urandom_range(5));
        endcase
    endfunction

    function automatic logic [7:0] separator_char();
        logic [7:0] seps [7];
        seps = '{htbp_pkg::CH_SPACE, htbp_pkg::CH_COLON, htbp_pkg::CH_DASH,
                 htbp_pkg::CH_COMMA, htbp_pkg::CH_TAB, htbp_pkg::CH_CR, htbp_pkg::CH_NL};
        return seps[$urandom_range(6)];
    endfunction

    task automatic send_prefix();
        send_item(htbp_pkg::OP_CHAR, htbp_pkg::CH_0);
        send_item(htbp_pkg::OP_CHAR,
                  $urandom_range(1) ? htbp_pkg::CH_LOW_X : htbp_pkg::CH_UP_X);
    endtask

    // mostly well-formed hex text, some junk, stray chars and odd digit counts
    task automatic send_random_string();
        int n_bytes;
        int noise_at;
        int drop_at;
        int pos;
        n_bytes = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(6);
        noise_at = ($urandom_range(6) == 0) ? $urandom_range(n_bytes) : -1;
        drop_at = ($urandom_range(9) == 0) ? $urandom_range(n_bytes) : -1;
        if ($urandom_range(3) == 0)
            send_prefix();
        for (pos = 0; pos <= n_bytes; pos++)
        begin
            if (pos == noise_at)
                send_item(htbp_pkg::OP_CHAR, 8'($urandom_range(255)));
            if (pos == n_bytes)
                break;
            if ($urandom_range(7) == 0)
                send_prefix();
            send_item(htbp_pkg::OP_CHAR, hex_char());
            if (pos != drop_at)
                send_item(htbp_pkg::OP_CHAR, hex_char());
            if ($urandom_range(2) == 0)
                send_item(htbp_pkg::OP_CHAR, separator_char());
        end
        send_item(htbp_pkg::OP_END, 8'($urandom_range(255)));
    endtask

    task automatic run_phase(logic [15:0] cap, int src_pct, int sink_pct, int n_items,
                             logic with_hold);
        int target;
        write_capacity(cap);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        if (with_hold)
        begin
            @(posedge clk);
            long_hold_req = 1'b1;
            @(negedge clk);
        end
        target = items_sent + n_items;
        while (items_sent < target)
            send_random_string();
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = htbp_pkg::OP_CHAR;
        char_code = 8'd0;
        out_stall = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = 16'd0;
        src_idle_pct = 0;
        sink_idle_pct = 0;
        items_sent = 0;
        strings_sent = 0;
        hold_left = 0;
        long_hold_req = 1'b0;
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        src_idle_pct = 31;
        sink_idle_pct = 51;
        send_item(htbp_pkg::OP_END, 8'hFF);
        send_text("0x1F");
        send_text("00:Ff");
        send_text("0 a");
        send_text("5X1");
        send_text("0");
        send_item(htbp_pkg::OP_CHAR, 8'hFF);
        send_item(htbp_pkg::OP_CHAR, 8'h33);
        send_item(htbp_pkg::OP_END, 8'h00);
        drain();

        run_phase(16'd3, 31, 51, 160, 1'b0);
        run_phase(16'd0, 31, 51, 150, 1'b0);
        run_phase(16'hFFFF, 51, 31, 160, 1'b0);
        run_phase(16'd1, 51, 31, 150, 1'b0);
        run_phase(16'($urandom_range(2, 12)), 0, 0, 170, 1'b1);
        run_phase(16'($urandom_range(65535)), 0, 0, 160, 1'b0);

        $display("Sent %0d items in %0d strings, checked %0d results.",
                 items_sent, strings_sent, sb.results_seen);
        $display("Capacities 0 to 65535, three idle mixes, one long output hold.");
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
